// ----- rtl/j5l_pkg.sv -----
// Shared types, codes and character helpers for the JSON5 token lexer.
`default_nettype none
package j5l_pkg;

  localparam int MAX_RESULTS = 3;
  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [2:0] {
    MODE_IDLE   = 3'd0,
    MODE_SLASH  = 3'd1,
    MODE_LINEC  = 3'd2,
    MODE_BLOCKC = 3'd3,
    MODE_SIGN   = 3'd4,
    MODE_NUM    = 3'd5,
    MODE_STR    = 3'd6,
    MODE_SYM    = 3'd7
  } mode_t;

  localparam logic [3:0] KIND_END    = 4'd0;
  localparam logic [3:0] KIND_LBRACE = 4'd1;
  localparam logic [3:0] KIND_RBRACE = 4'd2;
  localparam logic [3:0] KIND_LBRACK = 4'd3;
  localparam logic [3:0] KIND_RBRACK = 4'd4;
  localparam logic [3:0] KIND_COLON  = 4'd5;
  localparam logic [3:0] KIND_COMMA  = 4'd6;
  localparam logic [3:0] KIND_INT    = 4'd7;
  localparam logic [3:0] KIND_REAL   = 4'd8;
  localparam logic [3:0] KIND_STRING = 4'd9;
  localparam logic [3:0] KIND_BOOL   = 4'd10;
  localparam logic [3:0] KIND_NULL   = 4'd11;
  localparam logic [3:0] KIND_BADSYM = 4'd12;
  localparam logic [3:0] KIND_LONE   = 4'd13;

  localparam logic [2:0] ESC_BACKSLASH = 3'd7;
  localparam logic [2:0] ESC_UNICODE   = 3'd4;

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_UPPER_E = 8'h45;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_LOWER_E = 8'h65;
  localparam logic [7:0] CH_LOWER_U = 8'h75;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  typedef struct packed {
    logic [3:0]  kind;
    logic [31:0] offset;
    logic [31:0] length;
    logic [31:0] line;
    logic [7:0]  ch;
    logic        last;
  } result_t;

  function automatic logic is_white(input logic [7:0] c);
    return c == CH_TAB || c == CH_LF || c == CH_VT || c == CH_FF ||
           c == CH_CR || c == CH_SPACE;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic logic is_num_char(input logic [7:0] c);
    return is_digit(c) || c == CH_LOWER_E || c == CH_UPPER_E || c == CH_PLUS ||
           c == CH_MINUS || c == CH_DOT;
  endfunction

  function automatic logic is_break(input logic [7:0] c);
    return c == CH_LBRACE || c == CH_RBRACE || c == CH_LBRACK || c == CH_RBRACK ||
           c == CH_COLON || c == CH_COMMA || c == CH_PLUS || c == CH_MINUS ||
           c == CH_DOT || c == CH_DQUOTE || is_white(c);
  endfunction

  function automatic logic [7:0] char_true(input logic [2:0] pos);
    logic [7:0] ch;
    case (pos)
      3'd0:    ch = 8'h74;  // t
      3'd1:    ch = 8'h72;  // r
      3'd2:    ch = 8'h75;  // u
      default: ch = 8'h65;  // e
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] char_null(input logic [2:0] pos);
    logic [7:0] ch;
    case (pos)
      3'd0:    ch = 8'h6E;  // n
      3'd1:    ch = 8'h75;  // u
      default: ch = 8'h6C;  // l
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] char_false(input logic [2:0] pos);
    logic [7:0] ch;
    case (pos)
      3'd0:    ch = 8'h66;  // f
      3'd1:    ch = 8'h61;  // a
      3'd2:    ch = 8'h6C;  // l
      3'd3:    ch = 8'h73;  // s
      default: ch = 8'h65;  // e
    endcase
    return ch;
  endfunction

  // bits 2:0 = true/null/false still possible, bits 5:3 = saturating length
  function automatic logic [5:0] match_update(input logic [5:0] m, input logic [7:0] c);
    logic [2:0] pos;
    logic [2:0] bits;
    pos  = m[5:3];
    bits = m[2:0];
    if (!(pos < 3'd4 && c == char_true(pos)))  bits[0] = 1'b0;
    if (!(pos < 3'd4 && c == char_null(pos)))  bits[1] = 1'b0;
    if (!(pos < 3'd5 && c == char_false(pos))) bits[2] = 1'b0;
    if (pos < 3'd7) pos = pos + 3'd1;
    return {pos, bits};
  endfunction

  function automatic logic [3:0] symbol_kind(input logic [5:0] m);
    logic [3:0] k;
    if (m[5:3] == 3'd4 && m[0])      k = KIND_BOOL;
    else if (m[5:3] == 3'd4 && m[1]) k = KIND_NULL;
    else if (m[5:3] == 3'd5 && m[2]) k = KIND_BOOL;
    else                             k = KIND_BADSYM;
    return k;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/j5l_byte_if.sv -----
// Input channel carrying one text byte per request.
`default_nettype none
interface j5l_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       final_byte;

  modport source (output valid, output text_byte, output final_byte, input ready);
  modport sink (input valid, input text_byte, input final_byte, output ready);
endinterface
`default_nettype wire

// ----- rtl/j5l_token_if.sv -----
// Output channel carrying one token per request.
`default_nettype none
interface j5l_token_if;
  logic        valid;
  logic        ready;
  logic [3:0]  token_kind;
  logic [31:0] token_offset;
  logic [31:0] token_length;
  logic [31:0] token_line;
  logic [7:0]  token_char;
  logic        last_of_run;

  modport source (output valid, output token_kind, output token_offset,
                  output token_length, output token_line, output token_char,
                  output last_of_run, input ready);
  modport sink (input valid, input token_kind, input token_offset,
                input token_length, input token_line, input token_char,
                input last_of_run, output ready);
endinterface
`default_nettype wire

// ----- rtl/json5_token_lexer.sv -----
// JSON5 token lexer: text bytes in, tokens out.
// Usage:
//   text   : sink channel, one byte per request plus final_byte on the last byte of
//            a buffer. A byte is taken at an edge where valid and ready are high.
//   tokens : source channel, one token per request with kind, offset, length, line,
//            first char and last_of_run on the final token caused by a byte.
// Timing: a byte is lexed in the cycle it is taken; its tokens are registered in
//   the queue and leave it in order, one per cycle while tokens.ready is high.
// Throughput: one byte per cycle while each byte makes at most one token and the
//   consumer keeps up. A byte makes zero to three tokens; the four-entry token queue
//   takes a byte only while it has room for three; bursts drain one token per cycle.
// Reset (rst, synchronous): lexer back between tokens, offset 0, line 1, queue empty.
// After a final byte the lexer returns to the same state for the next buffer.
// Consumer stall: tokens wait in the queue; ready on the text side drops once fewer
//   than three free entries remain, and returns as tokens are drained.
`default_nettype none
module json5_token_lexer #(
  parameter int OFFSET_BITS = 32
) (
  input  wire logic  clk,
  input  wire logic  rst,
  j5l_byte_if.sink   text,
  j5l_token_if.source tokens
);
  import j5l_pkg::*;

  result_t    results [MAX_RESULTS];
  logic [1:0] push_cnt;
  logic       room;
  logic       accept;
  result_t    head;

  assign text.ready = room;
  assign accept     = text.valid && room;

  j5l_core #(.OFFSET_BITS(OFFSET_BITS)) u_core (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .text_byte  (text.text_byte),
    .final_byte (text.final_byte),
    .results    (results),
    .push_cnt   (push_cnt)
  );

  j5l_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .results    (results),
    .push_cnt   (push_cnt),
    .room       (room),
    .head_valid (tokens.valid),
    .head       (head),
    .pop        (tokens.ready)
  );

  assign tokens.token_kind   = head.kind;
  assign tokens.token_offset = head.offset;
  assign tokens.token_length = head.length;
  assign tokens.token_line   = head.line;
  assign tokens.token_char   = head.ch;
  assign tokens.last_of_run  = head.last;

endmodule
`default_nettype wire

// ----- rtl/j5l_core.sv -----
// Lexer state registers and the per-byte next-state and token logic.
`default_nettype none
module j5l_core #(
  parameter int OFFSET_BITS = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  accept,
  input  wire logic [7:0]            text_byte,
  input  wire logic                  final_byte,
  output j5l_pkg::result_t           results [j5l_pkg::MAX_RESULTS],
  output logic [1:0]                 push_cnt
);
  import j5l_pkg::*;

  typedef logic [OFFSET_BITS-1:0] cnt_t;

  mode_t      mode, mode_next;
  cnt_t       token_start, token_start_next;
  cnt_t       byte_offset, byte_offset_next;
  cnt_t       line_number, line_number_next;
  logic [2:0] escape_skip, escape_skip_next;
  logic       single_quote, single_quote_next;
  logic       integer_so_far, integer_so_far_next;
  logic [5:0] symbol_match, symbol_match_next;
  logic       star_seen, star_seen_next;
  logic [7:0] pending_char, pending_char_next;

  cnt_t       nxt;
  logic       do_idle;
  logic       a_emit, i_emit, f_close;
  result_t    a_tok, i_tok, f_tok, e_tok, mid_tok;
  logic [7:0] quote;
  logic [1:0] n;

  function automatic cnt_t sat_inc(input cnt_t v);
    return (&v) ? v : v + cnt_t'(1);
  endfunction

  function automatic result_t make_tok(input logic [3:0] kind, input cnt_t off,
                                       input cnt_t len, input cnt_t line,
                                       input logic [7:0] ch);
    result_t r;
    r.kind   = kind;
    r.offset = 32'(off);
    r.length = 32'(len);
    r.line   = 32'(line);
    r.ch     = ch;
    r.last   = 1'b0;
    return r;
  endfunction

  always_comb begin
    mode_next           = mode;
    token_start_next    = token_start;
    line_number_next    = line_number;
    escape_skip_next    = escape_skip;
    single_quote_next   = single_quote;
    integer_so_far_next = integer_so_far;
    symbol_match_next   = symbol_match;
    star_seen_next      = star_seen;
    pending_char_next   = pending_char;
    nxt      = sat_inc(byte_offset);
    do_idle  = 1'b0;
    a_emit   = 1'b0;
    i_emit   = 1'b0;
    f_close  = 1'b0;
    a_tok    = '0;
    i_tok    = '0;
    f_tok    = '0;
    quote    = single_quote ? CH_SQUOTE : CH_DQUOTE;

    // first look at the byte from the open token's point of view
    unique case (mode)
      MODE_SLASH: begin
        if (text_byte == CH_SLASH) begin
          mode_next = MODE_LINEC;
        end else if (text_byte == CH_STAR) begin
          mode_next      = MODE_BLOCKC;
          star_seen_next = 1'b1;
        end else begin
          a_emit  = 1'b1;
          a_tok   = make_tok(KIND_LONE, token_start, cnt_t'(1), line_number, pending_char);
          do_idle = 1'b1;
        end
      end
      MODE_LINEC: begin
        if (text_byte == CH_LF) begin
          line_number_next = sat_inc(line_number);
          mode_next        = MODE_IDLE;
        end
      end
      MODE_BLOCKC: begin
        // opener's star counts, so "/*/" closes
        if (text_byte == CH_SLASH && star_seen) begin
          mode_next      = MODE_IDLE;
          star_seen_next = 1'b0;
        end else begin
          if (text_byte == CH_LF) line_number_next = sat_inc(line_number);
          star_seen_next = (text_byte == CH_STAR);
        end
      end
      MODE_SIGN: begin
        if (is_digit(text_byte)) begin
          mode_next = MODE_NUM;
        end else begin
          a_emit  = 1'b1;
          a_tok   = make_tok(KIND_LONE, token_start, cnt_t'(1), line_number, pending_char);
          do_idle = 1'b1;
        end
      end
      MODE_NUM: begin
        if (is_num_char(text_byte)) begin
          if (text_byte == CH_DOT || text_byte == CH_LOWER_E || text_byte == CH_UPPER_E)
            integer_so_far_next = 1'b0;
        end else begin
          a_emit  = 1'b1;
          a_tok   = make_tok(integer_so_far ? KIND_INT : KIND_REAL, token_start,
                             byte_offset - token_start, line_number, pending_char);
          do_idle = 1'b1;
        end
      end
      MODE_STR: begin
        if (escape_skip == ESC_BACKSLASH) begin
          escape_skip_next = (text_byte == CH_LOWER_U) ? ESC_UNICODE : 3'd0;
        end else if (escape_skip != 3'd0) begin
          escape_skip_next = escape_skip - 3'd1;
        end else if (text_byte == CH_BSLASH) begin
          escape_skip_next = ESC_BACKSLASH;
        end else if (text_byte == quote) begin
          a_emit    = 1'b1;
          a_tok     = make_tok(KIND_STRING, token_start, nxt - token_start, line_number,
                               pending_char);
          mode_next = MODE_IDLE;
        end
      end
      MODE_SYM: begin
        if (is_break(text_byte)) begin
          a_emit  = 1'b1;
          a_tok   = make_tok(symbol_kind(symbol_match), token_start,
                             byte_offset - token_start, line_number, pending_char);
          do_idle = 1'b1;
        end else begin
          symbol_match_next = match_update(symbol_match, text_byte);
        end
      end
      default: do_idle = 1'b1;
    endcase

    // byte starts something new, possibly right after closing a token
    if (do_idle) begin
      mode_next = MODE_IDLE;
      if (is_white(text_byte)) begin
        if (text_byte == CH_LF) line_number_next = sat_inc(line_number_next);
      end else begin
        case (text_byte)
          CH_LBRACE: begin i_emit = 1'b1; i_tok.kind = KIND_LBRACE; end
          CH_RBRACE: begin i_emit = 1'b1; i_tok.kind = KIND_RBRACE; end
          CH_LBRACK: begin i_emit = 1'b1; i_tok.kind = KIND_LBRACK; end
          CH_RBRACK: begin i_emit = 1'b1; i_tok.kind = KIND_RBRACK; end
          CH_COLON:  begin i_emit = 1'b1; i_tok.kind = KIND_COLON; end
          CH_COMMA:  begin i_emit = 1'b1; i_tok.kind = KIND_COMMA; end
          default: begin
            token_start_next  = byte_offset;
            pending_char_next = text_byte;
            if (text_byte == CH_SLASH) begin
              mode_next = MODE_SLASH;
            end else if (text_byte == CH_PLUS || text_byte == CH_MINUS ||
                         text_byte == CH_DOT) begin
              mode_next           = MODE_SIGN;
              integer_so_far_next = (text_byte != CH_DOT);
            end else if (text_byte == CH_DQUOTE || text_byte == CH_SQUOTE) begin
              mode_next         = MODE_STR;
              single_quote_next = (text_byte == CH_SQUOTE);
              escape_skip_next  = 3'd0;
            end else if (is_digit(text_byte)) begin
              mode_next           = MODE_NUM;
              integer_so_far_next = 1'b1;
            end else begin
              mode_next         = MODE_SYM;
              symbol_match_next = match_update(6'd7, text_byte);
            end
          end
        endcase
        if (i_emit) begin
          i_tok.offset = 32'(byte_offset);
          i_tok.length = 32'd1;
          i_tok.line   = 32'(line_number_next);
          i_tok.ch     = text_byte;
        end
      end
    end

    // end of buffer: close what is open, then the end token
    e_tok = make_tok(KIND_END, nxt, '0, line_number_next, 8'h00);
    if (final_byte) begin
      case (mode_next)
        MODE_SLASH, MODE_SIGN: begin
          f_close = 1'b1;
          f_tok   = make_tok(KIND_LONE, token_start_next, cnt_t'(1), line_number_next,
                             pending_char_next);
        end
        MODE_NUM: begin
          f_close = 1'b1;
          f_tok   = make_tok(integer_so_far_next ? KIND_INT : KIND_REAL, token_start_next,
                             nxt - token_start_next, line_number_next, pending_char_next);
        end
        MODE_STR: begin
          f_close = 1'b1;
          f_tok   = make_tok(KIND_STRING, token_start_next, nxt - token_start_next,
                             line_number_next, pending_char_next);
        end
        MODE_SYM: begin
          f_close = 1'b1;
          f_tok   = make_tok(symbol_kind(symbol_match_next), token_start_next,
                             nxt - token_start_next, line_number_next, pending_char_next);
        end
        default: f_close = 1'b0;
      endcase
      byte_offset_next    = '0;
      mode_next           = MODE_IDLE;
      token_start_next    = '0;
      line_number_next    = cnt_t'(1);
      escape_skip_next    = 3'd0;
      single_quote_next   = 1'b0;
      integer_so_far_next = 1'b1;
      symbol_match_next   = 6'd0;
      star_seen_next      = 1'b0;
      pending_char_next   = 8'h00;
    end else begin
      byte_offset_next = nxt;
    end

    // pack the up to three tokens in order; a punctuator and a final close never coincide
    mid_tok      = i_emit ? i_tok : f_tok;
    a_tok.last   = !(i_emit || f_close || final_byte);
    mid_tok.last = !final_byte;
    e_tok.last   = 1'b1;
    for (int i = 0; i < MAX_RESULTS; i++) results[i] = e_tok;
    n = 2'd0;
    if (a_emit) begin
      results[n] = a_tok;
      n = n + 2'd1;
    end
    if (i_emit || f_close) begin
      results[n] = mid_tok;
      n = n + 2'd1;
    end
    if (final_byte) begin
      results[n] = e_tok;
      n = n + 2'd1;
    end
    push_cnt = accept ? n : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= MODE_IDLE;
      token_start    <= '0;
      byte_offset    <= '0;
      line_number    <= cnt_t'(1);
      escape_skip    <= 3'd0;
      single_quote   <= 1'b0;
      integer_so_far <= 1'b1;
      symbol_match   <= 6'd0;
      star_seen      <= 1'b0;
      pending_char   <= 8'h00;
    end else if (accept) begin
      mode           <= mode_next;
      token_start    <= token_start_next;
      byte_offset    <= byte_offset_next;
      line_number    <= line_number_next;
      escape_skip    <= escape_skip_next;
      single_quote   <= single_quote_next;
      integer_so_far <= integer_so_far_next;
      symbol_match   <= symbol_match_next;
      star_seen      <= star_seen_next;
      pending_char   <= pending_char_next;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/j5l_queue.sv -----
// Token queue: takes up to three tokens a cycle, hands out one a cycle while pop is high.
`default_nettype none
module j5l_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire j5l_pkg::result_t  results [j5l_pkg::MAX_RESULTS],
  input  wire logic [1:0]        push_cnt,
  output logic                   room,
  output logic                   head_valid,
  output j5l_pkg::result_t       head,
  input  wire logic              pop
);
  import j5l_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  result_t            entries [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [CNT_W-1:0]   count, count_next;
  logic               do_pop;

  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];
  assign do_pop     = pop && head_valid;
  // room for a full burst, so a byte never has to be held back mid-run
  assign room       = (count <= CNT_W'(QUEUE_DEPTH - MAX_RESULTS));
  assign count_next = count + CNT_W'(push_cnt) - CNT_W'(do_pop);

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_RESULTS; i++) begin
      if (2'(i) < push_cnt) entries[wr_ptr + PTR_W'(i)] <= results[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(push_cnt);
      if (do_pop) rd_ptr <= rd_ptr + PTR_W'(1);
      count <= count_next;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/j5l_checker.sv -----
// Port-level checks for the JSON5 token lexer, bound to the top level.
`default_nettype none
module j5l_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        in_final,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [3:0]  out_kind,
  input wire logic [31:0] out_offset,
  input wire logic [31:0] out_length,
  input wire logic        out_last
);
  import j5l_pkg::*;

  // a stalled token keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_offset)
                                && $stable(out_length) && $stable(out_last))
    else $error("token changed while stalled");

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("token offered right after reset");

  // the end token is always queued for a final byte
  a_final_emits: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_final |=> out_valid)
    else $error("no token after final byte");

  a_end_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind == KIND_END |-> out_last && out_length == 32'd0)
    else $error("end token malformed");

endmodule

bind json5_token_lexer j5l_checker u_j5l_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (text.valid),
  .in_ready   (text.ready),
  .in_final   (text.final_byte),
  .out_valid  (tokens.valid),
  .out_ready  (tokens.ready),
  .out_kind   (tokens.token_kind),
  .out_offset (tokens.token_offset),
  .out_length (tokens.token_length),
  .out_last   (tokens.last_of_run)
);
`default_nettype wire
